/* src/lkvc_pkg.sv */
// Shared constants, types and codes for the LRU key/value cache.
package lkvc_pkg;

    // Port field widths
    localparam int KEY_FIELD_W   = 64;
    localparam int VALUE_FIELD_W = 32;
    localparam int OCC_W         = 5;
    localparam int CAP_W         = 5;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF    = 16;
    localparam int DIMS_DEF       = 4;
    localparam int DIM_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Configuration port
    localparam int              APB_ADDR_W    = 3;
    localparam int              APB_DATA_W    = 32;
    localparam logic            REG_CAPACITY  = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;

    // Operation codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } t_dp_cmd;

endpackage

/* src/lkvc_ctrl.sv */
// Sequencer for the cache: input handshake, compare and update steps, result valid.
module lkvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output lkvc_pkg::t_dp_cmd o_cmd
);

    lkvc_pkg::t_state r_state;
    lkvc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkvc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_stall       = 1'b1;
        case (r_state)
            lkvc_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lkvc_pkg::ST_COMPARE;
                end
            end
            lkvc_pkg::ST_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE: begin
                // hold until the result register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.update = 1'b1;
                    n_state      = lkvc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.update | (r_out_valid & i_stall);
    end

    assign o_valid = r_out_valid;

endmodule

/* src/lkvc_datapath.sv */
// Entry store in recency order, parallel key compare, move-to-front and insert shifts.
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_W   = lkvc_pkg::KEY_FIELD_W,
    parameter int VAL_W   = lkvc_pkg::VALUE_FIELD_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lkvc_pkg::t_dp_cmd                   i_cmd,
    input  logic [lkvc_pkg::CAP_W-1:0]          i_capacity,
    input  logic                                i_func,
    input  logic [lkvc_pkg::KEY_FIELD_W-1:0]    i_key,
    input  logic [lkvc_pkg::VALUE_FIELD_W-1:0]  i_value_in,
    output logic                                o_hit,
    output logic [lkvc_pkg::VALUE_FIELD_W-1:0]  o_value_out,
    output logic [lkvc_pkg::OCC_W-1:0]          o_occupancy
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = CNT_W + lkvc_pkg::CAP_W;

    logic [KEY_W-1:0] r_key [ENTRIES];
    logic [VAL_W-1:0] r_val [ENTRIES];
    logic [CNT_W-1:0] r_count;
    logic             r_func;
    logic [KEY_W-1:0] r_key_in;
    logic [VAL_W-1:0] r_val_in;
    logic [ENTRIES-1:0] r_match;
    logic             r_hit;
    logic [VAL_W-1:0] r_value_out;

    logic [ENTRIES-1:0] below;
    logic               any_hit;
    logic [KEY_W-1:0]   hit_key;
    logic [VAL_W-1:0]   hit_val;
    logic [EXT_W-1:0]   cap_ext;
    logic [EXT_W-1:0]   cap_eff;
    logic [EXT_W-1:0]   inc_ext;
    logic [EXT_W-1:0]   ins_count;
    logic [CNT_W-1:0]   count_inc;
    logic [EXT_W-1:0]   occ_ext;
    logic [VAL_W+lkvc_pkg::VALUE_FIELD_W-1:0] vout_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update && r_func == lkvc_pkg::FUNC_INSERT) begin
            r_count <= ins_count[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_key_in <= i_key[KEY_W-1:0];
            r_val_in <= i_value_in[VAL_W-1:0];
        end
    end

    // Compare every live slot against the key
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cmp
        always_ff @(posedge i_clk) begin
            if (i_cmd.compare) begin
                r_match[g] <= (CNT_W'(g) < r_count) && (r_key[g] == r_key_in);
            end
        end
    end

    // First match from the most recent slot; below[i] marks a match ahead of slot i
    always_comb begin
        below[0] = 1'b0;
        for (int i = 1; i < ENTRIES; i++) begin
            below[i] = below[i-1] | r_match[i-1];
        end
        any_hit = |r_match;
        hit_key = '0;
        hit_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i] && !below[i]) begin
                hit_key = hit_key | r_key[i];
                hit_val = hit_val | r_val[i];
            end
        end
    end

    // Count after an insert: bump, saturate at depth, clamp to the capacity
    always_comb begin
        count_inc = (r_count < CNT_W'(ENTRIES)) ? r_count + 1'b1 : r_count;
        inc_ext   = EXT_W'(count_inc);
        cap_ext   = EXT_W'(i_capacity);
        if (i_capacity == '0) begin
            cap_eff = EXT_W'(1);
        end else if (cap_ext > EXT_W'(ENTRIES)) begin
            cap_eff = EXT_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
        ins_count = (inc_ext > cap_eff) ? cap_eff : inc_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (r_func == lkvc_pkg::FUNC_INSERT) begin
                for (int i = 1; i < ENTRIES; i++) begin
                    r_key[i] <= r_key[i-1];
                    r_val[i] <= r_val[i-1];
                end
                r_key[0] <= r_key_in;
                r_val[0] <= r_val_in;
            end else if (any_hit) begin
                // advance slots ahead of the hit, then put the hit at the front
                for (int i = 1; i < ENTRIES; i++) begin
                    if (!below[i]) begin
                        r_key[i] <= r_key[i-1];
                        r_val[i] <= r_val[i-1];
                    end
                end
                r_key[0] <= hit_key;
                r_val[0] <= hit_val;
            end
            r_hit       <= (r_func == lkvc_pkg::FUNC_LOOKUP) && any_hit;
            r_value_out <= ((r_func == lkvc_pkg::FUNC_LOOKUP) && any_hit) ? hit_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            occ_ext <= (r_func == lkvc_pkg::FUNC_INSERT) ? ins_count : EXT_W'(r_count);
        end
    end

    assign vout_ext    = {{lkvc_pkg::VALUE_FIELD_W{1'b0}}, r_value_out};
    assign o_hit       = r_hit;
    assign o_value_out = vout_ext[lkvc_pkg::VALUE_FIELD_W-1:0];
    assign o_occupancy = occ_ext[lkvc_pkg::OCC_W-1:0];

endmodule

/* src/lru_key_value_cache.sv */
// LRU key/value cache top level: capacity register, sequencer and entry datapath.
// Flow: an accepted word is captured, compared (the key compare is registered), then
//   applied in the update step, which waits while the result word ahead is stalled; no new
//   word enters until the shift update of the shared entry store is done.
// Reset (synchronous, active low) empties the store and sets the capacity to 16;
//   entry contents are not cleared, only the entry count.
module lru_key_value_cache #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int DIMS       = lkvc_pkg::DIMS_DEF,
    parameter int DIM_BITS   = lkvc_pkg::DIM_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic [lkvc_pkg::KEY_FIELD_W-1:0]    i_key,
    input  logic [lkvc_pkg::VALUE_FIELD_W-1:0]  i_value_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [lkvc_pkg::VALUE_FIELD_W-1:0]  o_value_out,
    output logic [lkvc_pkg::OCC_W-1:0]          o_occupancy,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lkvc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int KEY_RAW = DIMS * DIM_BITS;
    localparam int KEY_W   = (KEY_RAW > lkvc_pkg::KEY_FIELD_W) ? lkvc_pkg::KEY_FIELD_W : KEY_RAW;
    localparam int VAL_W   = (VALUE_BITS > lkvc_pkg::VALUE_FIELD_W) ?
                             lkvc_pkg::VALUE_FIELD_W : VALUE_BITS;

    logic [lkvc_pkg::CAP_W-1:0] r_capacity;
    logic                       reg_sel;
    lkvc_pkg::t_dp_cmd          cmd;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == lkvc_pkg::REG_CAPACITY) && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata[lkvc_pkg::CAP_W-1:0] = r_capacity;
        end
    end

    lkvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .VAL_W   (VAL_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_capacity  (r_capacity),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_value_in  (i_value_in),
        .o_hit       (o_hit),
        .o_value_out (o_value_out),
        .o_occupancy (o_occupancy)
    );

endmodule
